FILE: sv/pfr_pkg.sv
// Package for the polyphase FIR resampler: field widths, op codes, FSM states.
// No dependencies.
`default_nettype none
package pfr_pkg;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 24;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned AccW     = 21;
  localparam int unsigned ProdW    = SampleW + CoefW;
  localparam int unsigned SumW     = 56;
  localparam int unsigned DefTaps   = 64;
  localparam int unsigned DefPhases = 32;
  localparam int unsigned RunMax   = 25;
  localparam logic [AccW-1:0] OneQ16    = AccW'(65536);
  localparam logic [AccW-1:0] AccMax    = {AccW{1'b1}};
  localparam logic [AccW-1:0] StepReset = AccW'(65536);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_OUT,
    ST_CLEAR
  } state_e;

  // Control that the sequencer hands to the row of history cells.
  typedef struct packed {
    logic shift;   // rotate the ring one place
    logic load;    // write a new sample into the head cell
    logic clear;   // zero every cell
  } hist_ctrl_t;
endpackage
`default_nettype wire

FILE: sv/pfr_if.sv
// Valid/ready channel interfaces for the resampler.
// Depends on pfr_pkg.
`default_nettype none
interface pfr_in_if;
  import pfr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [SampleW-1:0] sample_in;
  logic [IdxW-1:0]          coef_index;
  logic signed [CoefW-1:0]  coef_value;
  modport source (output valid, op, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, op, sample_in, coef_index, coef_value, output ready);
endinterface

interface pfr_out_if;
  import pfr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] out_sample;
  logic                      last_of_run;
  modport source (output valid, out_sample, last_of_run, input ready);
  modport sink   (input valid, out_sample, last_of_run, output ready);
endinterface
`default_nettype wire

FILE: sv/pfr_cell.sv
// One history cell: holds a sample and passes it to its neighbour on a shift.
// Depends on pfr_pkg.
`default_nettype none
module pfr_cell
  import pfr_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hist_ctrl_t                ctrl_i,
  input  wire logic signed [SampleW-1:0] prev_i,
  input  wire logic signed [SampleW-1:0] new_i,
  input  wire logic                      head_i,
  output logic signed [SampleW-1:0]      data_o
);
  logic signed [SampleW-1:0] data_q, data_d;

  // The head cell takes the new sample on a load; others take their neighbour.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.clear) begin
      data_d = '0;
    end else if (ctrl_i.load) begin
      data_d = head_i ? new_i : prev_i;
    end else if (ctrl_i.shift) begin
      data_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
endmodule
`default_nettype wire

FILE: sv/pfr_hist.sv
// Ring of history cells, newest sample at cell 0, rotated once per tap.
// Depends on pfr_pkg and pfr_cell.
`default_nettype none
module pfr_hist
  import pfr_pkg::*;
#(
  parameter int unsigned Taps = DefTaps
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hist_ctrl_t                ctrl_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  output logic signed [SampleW-1:0]      head_o
);
  logic signed [SampleW-1:0] cell_data [Taps];

  // A load shifts the ring one place older and puts the sample at the head.
  // A shift rotates towards the head, so Taps shifts restore the order.
  for (genvar i = 0; i < Taps; i++) begin : g_cell
    logic signed [SampleW-1:0] prev;
    if (i == Taps - 1) begin : g_last
      assign prev = ctrl_i.load ? cell_data[i-1] : cell_data[0];
    end else if (i == 0) begin : g_first
      assign prev = cell_data[1];
    end else begin : g_mid
      assign prev = ctrl_i.load ? cell_data[i-1] : cell_data[i+1];
    end
    pfr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .prev_i (prev),
      .new_i  (sample_i),
      .head_i (i == 0),
      .data_o (cell_data[i])
    );
  end

  assign head_o = cell_data[0];
endmodule
`default_nettype wire

FILE: sv/polyphase_fir_resampler.sv
// Top level of the polyphase FIR resampler: sequencer, coefficient memory, MAC.
// Depends on pfr_pkg, pfr_if and pfr_hist.
//
// Usage: items arrive on in_ch (op, sample_in, coef_index, coef_value) and
// results leave on out_ch (out_sample, last_of_run), both valid/ready.
// phase_step is to be written by the user through cfg_we_i/cfg_wdata_i only
// while the block is idle; the block does not enforce this. A coefficient or
// clear item is handled in the idle state without leaving it (a clear rotates
// nothing: every history cell zeroes at once). A sample item produces zero to
// 25 results; each one is a dot product over TAPS taps done by one shared
// multiply-accumulate unit walking the rotating row of history cells, so the
// results of one sample are computed one after another. The block takes the
// next item only after its run ends. A result sits in the output register
// until taken; a receiver stall just holds the sequencer. Reset zeroes
// history and accumulator, and sets phase_step to one; the coefficient
// memory is undefined until written.
`default_nettype none
module polyphase_fir_resampler
  import pfr_pkg::*;
#(
  parameter int unsigned Taps   = DefTaps,
  parameter int unsigned Phases = DefPhases
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  pfr_in_if.sink               in_ch,
  pfr_out_if.source            out_ch,
  input  wire logic            cfg_we_i,
  input  wire logic [AccW-1:0] cfg_wdata_i
);
  localparam int unsigned Depth  = Taps * Phases;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned PhW    = $clog2(Phases);
  localparam int unsigned CntW   = $clog2(Taps + 1);
  localparam int unsigned RunW   = $clog2(RunMax + 1);

  state_e state_q, state_d;
  logic [AccW-1:0]  step_q, acc_q, acc_d;
  logic [CntW-1:0]  tap_q, tap_d;
  logic [RunW-1:0]  run_q, run_d;
  logic [PhW-1:0]   phase_q, phase_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [CoefW-1:0] coef_q;
  logic signed [SampleW-1:0] samp_q;
  logic             prod_v_q, mul_v_q, mul_v_d;
  logic signed [SampleW-1:0] out_q, out_d;
  logic             last_q, last_d, ovalid_q, ovalid_d;
  hist_ctrl_t       hctl;
  logic signed [SampleW-1:0] head;
  logic [CoefW-1:0] mem [Depth];
  logic [AddrW-1:0] raddr;
  logic             mem_we;
  logic             in_fire;
  logic [AccW+PhW-1:0] acc_ph;
  logic [AccW:0]    acc_sum;
  logic signed [SumW-1:0] q_full;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);
  assign mem_we = in_fire && (in_ch.op == OP_COEF) && (32'(in_ch.coef_index) < Depth);

  // Phase step register setting.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Coefficient memory: one write port, one registered read port.
  assign raddr = AddrW'(32'(phase_q) * Taps + 32'(tap_q));
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[in_ch.coef_index[AddrW-1:0]] <= in_ch.coef_value;
    end
    coef_q <= mem[raddr];
  end

  pfr_hist #(.Taps(Taps)) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (hctl),
    .sample_i (in_ch.sample_in),
    .head_o   (head)
  );

  // Phase of the next result, clamped.
  assign acc_ph = ({{PhW{1'b0}}, acc_q} * (AccW+PhW)'(Phases)) >> 16;
  assign acc_sum = {1'b0, acc_q} + {1'b0, step_q};
  // Floor shift then saturate.
  assign q_full = sum_q >>> 16;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    tap_d   = tap_q;
    run_d   = run_q;
    phase_d = phase_q;
    sum_d   = sum_q;
    mul_v_d = 1'b0;
    out_d   = out_q;
    last_d  = last_q;
    ovalid_d = ovalid_q && !out_ch.ready;
    hctl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == OP_SAMPLE) begin
            hctl.load = 1'b1;
            run_d = '0;
            state_d = ST_CHECK;
          end else if (in_ch.op == OP_CLEAR) begin
            hctl.clear = 1'b1;
            acc_d = '0;
          end
        end
      end
      ST_CHECK: begin
        if (acc_q < OneQ16 && run_q < RunW'(RunMax)) begin
          phase_d = (acc_ph > (AccW+PhW)'(Phases - 1)) ? PhW'(Phases - 1) : acc_ph[PhW-1:0];
          tap_d = '0;
          sum_d = '0;
          state_d = ST_MAC;
        end else begin
          acc_d = (acc_q >= OneQ16) ? acc_q - OneQ16 : '0;
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        // One tap a cycle: memory read and ring rotation advance together.
        mul_v_d = 1'b1;
        hctl.shift = 1'b1;
        tap_d = tap_q + 1'b1;
        if (tap_q == CntW'(Taps - 1)) begin
          state_d = ST_DRAIN;
          tap_d = '0;
        end
      end
      ST_DRAIN: begin
        tap_d = tap_q + 1'b1;
        if (tap_q == CntW'(2)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || out_ch.ready) begin
          out_d = (q_full > SumW'(32767)) ? 16'sh7FFF :
                  (q_full < -SumW'(32768)) ? -16'sh8000 : q_full[SampleW-1:0];
          acc_d = acc_sum > {1'b0, AccMax} ? AccMax : acc_sum[AccW-1:0];
          last_d = (acc_d >= OneQ16) || (run_q == RunW'(RunMax - 1));
          ovalid_d = 1'b1;
          run_d = run_q + 1'b1;
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (prod_v_q) begin
      sum_d = sum_q + SumW'(prod_q);
    end
  end

  // MAC pipeline: coefficient and sample registered, product, accumulate.
  always_ff @(posedge clk_i) begin
    samp_q <= head;
    prod_q <= coef_q * samp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q <= '0;
      tap_q <= '0;
      run_q <= '0;
      phase_q <= '0;
      sum_q <= '0;
      mul_v_q <= 1'b0;
      prod_v_q <= 1'b0;
      out_q <= '0;
      last_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q <= acc_d;
      tap_q <= tap_d;
      run_q <= run_d;
      phase_q <= phase_d;
      sum_q <= sum_d;
      mul_v_q <= mul_v_d;
      prod_v_q <= mul_v_q;
      out_q <= out_d;
      last_q <= last_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_ch.valid = ovalid_q;
  assign out_ch.out_sample = out_q;
  assign out_ch.last_of_run = last_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.out_sample)))
    else $error("result dropped under stall");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RunW'(RunMax)) else $error("run too long");
`endif
endmodule
`default_nettype wire

FILE: sim/tb_polyphase_fir_resampler.sv
// Testbench for the polyphase FIR resampler: directed and random items against a
// built-in predictor. Depends on pfr_pkg, pfr_if and the RTL of the block.
`default_nettype none
module tb_polyphase_fir_resampler;
  import pfr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTaps   = DefTaps;
  localparam int NPhases = DefPhases;
  localparam int TabSize = NTaps * NPhases;
  localparam int StallLimit = 20000;
  // Steps are whole multiples of half a unit, so the accumulator only ever
  // selects phase 0 or the middle phase and only those two rows are loaded.
  localparam int StepUnit = 32768;

  typedef struct {
    logic signed [SampleW-1:0] smp;
    logic                      last;
  } resampled_t;

  // Predicts the resampled outputs and holds those still awaited.
  class resample_scoreboard;
    logic signed [SampleW-1:0] ring[NTaps];
    int unsigned               wr_pos;
    logic [AccW-1:0]           acc;
    logic [AccW-1:0]           step;
    logic signed [CoefW-1:0]   coefs[TabSize];
    resampled_t                pending[$];
    int                        errors;

    function void reset_state();
      foreach (ring[i]) ring[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      wr_pos = 0;
      acc = '0;
      step = StepReset;
      errors = 0;
    endfunction

    function logic signed [SampleW-1:0] fir_row(int unsigned ph);
      logic signed [63:0] sum;
      logic signed [63:0] q;
      sum = 0;
      for (int k = 0; k < NTaps; k++) begin
        sum += 64'(coefs[ph * NTaps + k]) * 64'(ring[(wr_pos + NTaps - 1 - k) % NTaps]);
      end
      q = sum >>> 16;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[SampleW-1:0];
    endfunction

    function void note_item(op_e op, logic signed [SampleW-1:0] s,
                            logic [IdxW-1:0] idx, logic signed [CoefW-1:0] c);
      int unsigned n;
      int unsigned ph;
      logic [AccW:0] nxt;
      resampled_t r;
      case (op)
        OP_COEF: begin
          if (idx < TabSize) coefs[idx] = c;
        end
        OP_CLEAR: begin
          foreach (ring[i]) ring[i] = '0;
          wr_pos = 0;
          acc = '0;
        end
        OP_SAMPLE: begin
          ring[wr_pos] = s;
          wr_pos = (wr_pos + 1) % NTaps;
          n = 0;
          while (acc < OneQ16 && n < RunMax) begin
            ph = (32'(acc) * NPhases) >> 16;
            if (ph > NPhases - 1) ph = NPhases - 1;
            r.smp = fir_row(ph);
            r.last = 1'b0;
            pending.push_back(r);
            nxt = {1'b0, acc} + {1'b0, step};
            acc = (nxt > AccMax) ? AccMax : nxt[AccW-1:0];
            n++;
          end
          if (n > 0) pending[$].last = 1'b1;
          acc = (acc >= OneQ16) ? acc - OneQ16 : '0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [SampleW-1:0] s, logic l);
      resampled_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual out_sample %0d last_of_run %0b",
                 $time, s, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (s !== e.smp) begin
        $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time, e.smp, s);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last_of_run mismatch, expected %0b, actual %0b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [AccW-1:0] cfg_wdata_i;
  pfr_in_if  in_ch ();
  pfr_out_if out_ch ();

  resample_scoreboard sb;
  int  idle_cycles;

  polyphase_fir_resampler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Score accepted items and results, and watch for a stuck block.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item(op_e'(in_ch.op), in_ch.sample_in, in_ch.coef_index, in_ch.coef_value);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_sample, out_ch.last_of_run);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (!in_ch.valid && sb.pending.size() == 0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // The receiver stalls in runs of its own, sometimes not at all.
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(4, 60)) begin
        @(posedge clk_i);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 1) != 0);
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Sends one item and holds it until the block takes it.
  task automatic send_item(op_e op, logic signed [SampleW-1:0] s,
                           logic [IdxW-1:0] idx, logic signed [CoefW-1:0] c);
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.sample_in  <= s;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  // Sends a burst-shaped stream: valid stays high within a burst.
  task automatic send_paced(op_e op, logic signed [SampleW-1:0] s,
                            logic [IdxW-1:0] idx, logic signed [CoefW-1:0] c);
    send_item(op, s, idx, c);
    if ($urandom_range(0, 4) == 0) pause_sender();
  endtask

  // Waits for every awaited result, then lets the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * (NTaps + 5) + 8) @(posedge clk_i);
  endtask

  task automatic write_step(logic [AccW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.step = v;
    @(posedge clk_i);
  endtask

  // Loads the two rows in use: small values, extremes and full-range values.
  task automatic load_table();
    logic signed [CoefW-1:0] c;
    for (int p = 0; p < NPhases; p += NPhases / 2) begin
      for (int k = 0; k < NTaps; k++) begin
        case ($urandom_range(0, 2))
          0: c = CoefW'($urandom_range(0, 2 ** 20)) - CoefW'(2 ** 19);
          1: c = ($urandom_range(0, 1) != 0) ? 24'sh7FFFFF : 24'sh800000;
          default: c = CoefW'($urandom);
        endcase
        send_item(OP_COEF, SampleW'($urandom), IdxW'(p * NTaps + k), c);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_samples(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) send_paced(OP_CLEAR, SampleW'($urandom), IdxW'($urandom), CoefW'($urandom));
      else if (r == 1) send_paced(OP_NONE, SampleW'($urandom), IdxW'($urandom),
                                  CoefW'($urandom));
      else if (r == 2) send_paced(OP_COEF, SampleW'($urandom),
                                  IdxW'($urandom_range(TabSize, 2047)), CoefW'($urandom));
      else if (r == 3) send_paced(OP_COEF, SampleW'($urandom),
                                  IdxW'($urandom_range(0, TabSize - 1)), CoefW'($urandom));
      else if (r == 4) send_paced(OP_SAMPLE, ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000,
                                  IdxW'($urandom), CoefW'($urandom));
      else send_paced(OP_SAMPLE, SampleW'($urandom), IdxW'($urandom), CoefW'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_NONE;
    in_ch.sample_in = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rows in use first, so no unwritten coefficient is ever read.
    load_table();
    // Directed: extreme samples at the reset step, the unused op, coefficient
    // writes at the top address and twice at address 0, and a clear.
    send_item(OP_SAMPLE, 16'sh7FFF, '0, '0);
    send_item(OP_SAMPLE, 16'sh8000, '0, '0);
    send_item(OP_SAMPLE, 16'sh7FFF, '0, '0);
    send_item(OP_NONE, 16'sh7FFF, 11'h7FF, 24'sh7FFFFF);
    send_item(OP_COEF, '0, 11'h7FF, 24'sh123456);
    send_item(OP_COEF, '0, IdxW'(TabSize), 24'sh800000);
    send_item(OP_COEF, '0, '0, 24'sh7FFFFF);
    send_item(OP_SAMPLE, '0, '0, '0);
    send_item(OP_CLEAR, 16'sh1234, '0, '0);
    send_item(OP_SAMPLE, 16'sh7FFF, '0, '0);
    drain();
    // Half-unit step: two results per sample, on both rows.
    write_step(AccW'(StepUnit));
    for (int i = 0; i < 4; i++) send_item(OP_SAMPLE, SampleW'($urandom), '0, '0);
    drain();
    // Largest step: most samples give no result.
    write_step(AccW'(1572864));
    for (int i = 0; i < 6; i++) send_item(OP_SAMPLE, SampleW'($urandom), '0, '0);
    send_item(OP_CLEAR, '0, '0, '0);
    drain();

    // Random phases, each with its own step.
    write_step(AccW'(65536));
    random_samples(40);
    drain();
    write_step(AccW'(StepUnit * $urandom_range(1, 2)));
    random_samples(40);
    drain();
    write_step(AccW'(StepUnit * $urandom_range(1, 48)));
    random_samples(50);
    drain();
    write_step(AccW'(StepUnit));
    random_samples(40);
    drain();
    write_step(AccW'(StepUnit * $urandom_range(2, 48)));
    random_samples(50);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
